@@ src/pre_pkg.sv @@
// Shared types and constants for the page replacement engine.
package pre_pkg;

    // Default sizes of the frame table.
    localparam int DEF_FRAMES     = 16;
    localparam int DEF_PAGE_BITS  = 16;
    localparam int DEF_STAMP_BITS = 32;
    localparam int DEF_COUNT_BITS = 16;

    // Fixed widths of the ports.
    localparam int PAGE_W     = 16;
    localparam int FRAME_W    = 4;
    localparam int TOTAL_W    = 32;
    localparam int MODE_W     = 3;
    localparam int NFRAMES_W  = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    localparam logic [NFRAMES_W-1:0] NFRAMES_RESET = NFRAMES_W'(16);

    typedef enum logic [MODE_W-1:0] {
        POL_FIFO  = 3'd0,
        POL_LRU   = 3'd1,
        POL_LFU   = 3'd2,
        POL_MFU   = 3'd3,
        POL_CLOCK = 3'd4
    } t_policy;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POLICY_MODE   = 1'b0,
        CFG_FRAMES_IN_USE = 1'b1
    } t_cfg_idx;

    // Where a faulting page goes.
    typedef enum logic [1:0] {
        LD_EMPTY = 2'd0,  // next unfilled frame
        LD_BEST  = 2'd1,  // tracked victim (or the hand when every bit is set)
        LD_CUR   = 2'd2   // frame whose data is on the read port
    } t_load_sel;

    typedef struct packed {
        logic      start;
        logic      issue;
        logic      track;
        logic      hit_upd;
        logic      sweep_start;
        logic      clr_ref;
        logic      load;
        t_load_sel load_sel;
        logic      emit;
    } t_dp_cmd;

    typedef struct packed {
        logic dv;
        logic match;
        logic refbit;
        logic all_issued;
        logic full;
        logic clock;
    } t_dp_sts;

endpackage

@@ src/pre_ctrl.sv @@
// Controller: sequences lookup, clock sweep, load and result hand-off.
module pre_ctrl import pre_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOKUP,
        S_SWEEP,
        S_FINISH
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        o_cmd       = '0;
        o_cmd.load_sel = LD_EMPTY;
        n_state     = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                if (i_sts.dv && i_sts.match) begin
                    o_cmd.hit_upd = 1'b1;
                    n_state       = S_FINISH;
                end else if (!i_sts.dv && i_sts.all_issued) begin
                    if (!i_sts.full) begin
                        o_cmd.load     = 1'b1;
                        o_cmd.load_sel = LD_EMPTY;
                        n_state        = S_FINISH;
                    end else if (!i_sts.clock) begin
                        o_cmd.load     = 1'b1;
                        o_cmd.load_sel = LD_BEST;
                        n_state        = S_FINISH;
                    end else begin
                        o_cmd.sweep_start = 1'b1;
                        n_state           = S_SWEEP;
                    end
                end else begin
                    o_cmd.issue = !i_sts.all_issued;
                    o_cmd.track = i_sts.dv;
                end
            end
            S_SWEEP: begin
                if (i_sts.dv && !i_sts.refbit) begin
                    o_cmd.load     = 1'b1;
                    o_cmd.load_sel = LD_CUR;
                    n_state        = S_FINISH;
                end else if (!i_sts.dv && i_sts.all_issued) begin
                    // every bit was set: replace at the hand
                    o_cmd.load     = 1'b1;
                    o_cmd.load_sel = LD_BEST;
                    n_state        = S_FINISH;
                end else begin
                    o_cmd.issue   = !i_sts.all_issued;
                    o_cmd.track   = i_sts.dv;
                    o_cmd.clr_ref = i_sts.dv;
                end
            end
            S_FINISH: begin
                // hold until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if (o_cmd.emit)
            n_out_valid = 1'b1;
        else if (i_out_ready)
            n_out_valid = 1'b0;
        else
            n_out_valid = r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

`ifndef SYNTHESIS
    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.hit_upd, o_cmd.load, o_cmd.clr_ref}))
        else $error("more than one table write in a cycle");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_out_valid) |-> $past(i_out_ready) || !$past(i_rst_n))
        else $error("result dropped without a transaction");
`endif

endmodule

@@ src/pre_datapath.sv @@
// Datapath: frame table, scan pipeline, victim tracking, counters and result registers.
module pre_datapath import pre_pkg::*; #(
    parameter int FRAMES     = DEF_FRAMES,
    parameter int PAGE_BITS  = DEF_PAGE_BITS,
    parameter int STAMP_BITS = DEF_STAMP_BITS,
    parameter int COUNT_BITS = DEF_COUNT_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [PAGE_W-1:0]     i_page,
    input  t_dp_cmd               i_cmd,
    output t_dp_sts               o_sts,
    output logic                  o_hit,
    output logic [FRAME_W-1:0]    o_frame_used,
    output logic                  o_evicted_valid,
    output logic [PAGE_W-1:0]     o_evicted_page,
    output logic [TOTAL_W-1:0]    o_hit_total,
    output logic [TOTAL_W-1:0]    o_fault_total
);

    localparam int FIDX = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CNTW = $clog2(FRAMES + 1);

    // Frame table
    logic [PAGE_BITS-1:0]  mem_page  [FRAMES];
    logic [STAMP_BITS-1:0] mem_stamp [FRAMES];
    logic [COUNT_BITS-1:0] mem_uses  [FRAMES];
    logic                  mem_ref   [FRAMES];

    // Configuration and persistent state
    logic [MODE_W-1:0]     r_cfg_mode;
    logic [NFRAMES_W-1:0]  r_cfg_frames;
    logic [CNTW-1:0]       r_filled;
    logic [FIDX-1:0]       r_hand;
    logic [STAMP_BITS-1:0] r_refcnt;
    logic [TOTAL_W-1:0]    r_hits;
    logic [TOTAL_W-1:0]    r_faults;

    // Scan pipeline
    logic [PAGE_BITS-1:0]  r_page;
    logic [FIDX-1:0]       r_addr;
    logic [CNTW-1:0]       r_issued;
    logic                  r_sweep;
    logic                  r_dv;
    logic [FIDX-1:0]       r_didx;
    logic [PAGE_BITS-1:0]  r_rd_page;
    logic [STAMP_BITS-1:0] r_rd_stamp;
    logic [COUNT_BITS-1:0] r_rd_uses;
    logic                  r_rd_ref;

    // Victim tracking
    logic                  r_best_v;
    logic [FIDX-1:0]       r_best_idx;
    logic [PAGE_BITS-1:0]  r_best_page;
    logic [STAMP_BITS-1:0] r_best_stamp;
    logic [COUNT_BITS-1:0] r_best_uses;

    // Result of the current item and the output register
    logic                  r_res_hit;
    logic [FIDX-1:0]       r_res_slot;
    logic                  r_res_evict;
    logic [PAGE_BITS-1:0]  r_res_old;
    logic                  r_out_hit;
    logic [FRAME_W-1:0]    r_out_frame;
    logic                  r_out_evict;
    logic [PAGE_W-1:0]     r_out_old;

    logic [CNTW-1:0]       w_count;
    t_policy               w_mode;
    logic [CNTW-1:0]       w_filled_inc;
    logic [FIDX-1:0]       w_victim;
    logic [PAGE_BITS-1:0]  w_victim_page;
    logic                  w_better;
    logic                  w_take;

    logic                  w_we_page, w_we_stamp, w_we_uses, w_we_ref;
    logic [FIDX-1:0]       w_waddr;
    logic [STAMP_BITS-1:0] w_wstamp;
    logic [COUNT_BITS-1:0] w_wuses;
    logic                  w_wref;

    function automatic logic [FIDX-1:0] f_next(input logic [FIDX-1:0] idx,
                                                input logic [CNTW-1:0] cnt);
        f_next = ((CNTW'(idx) + 1'b1) == cnt) ? '0 : idx + 1'b1;
    endfunction

    always_comb begin
        if (r_cfg_frames == '0)
            w_count = CNTW'(1);
        else if (int'(r_cfg_frames) > FRAMES)
            w_count = CNTW'(FRAMES);
        else
            w_count = CNTW'(r_cfg_frames);
    end

    // Unused codes act as FIFO.
    assign w_mode = (r_cfg_mode > MODE_W'(POL_CLOCK)) ? POL_FIFO : t_policy'(r_cfg_mode);

    assign w_filled_inc = r_filled + 1'b1;

    always_comb begin
        case (i_cmd.load_sel)
            LD_EMPTY: begin
                w_victim      = r_filled[FIDX-1:0];
                w_victim_page = '0;
            end
            LD_BEST: begin
                w_victim      = r_best_idx;
                w_victim_page = r_best_page;
            end
            LD_CUR: begin
                w_victim      = r_didx;
                w_victim_page = r_rd_page;
            end
            default: begin
                w_victim      = r_best_idx;
                w_victim_page = r_best_page;
            end
        endcase
    end

    // Is the entry on the read port a better victim than the tracked one?
    always_comb begin
        if (w_mode == POL_LFU && r_rd_uses != r_best_uses)
            w_better = r_rd_uses < r_best_uses;
        else if (w_mode == POL_MFU && r_rd_uses != r_best_uses)
            w_better = r_rd_uses > r_best_uses;
        else
            w_better = r_rd_stamp < r_best_stamp;
    end

    // The sweep keeps only its first entry: the hand.
    assign w_take = !r_best_v || (!r_sweep && w_better);

    // Table write port
    always_comb begin
        w_we_page  = 1'b0;
        w_we_stamp = 1'b0;
        w_we_uses  = 1'b0;
        w_we_ref   = 1'b0;
        w_waddr    = r_didx;
        w_wstamp   = r_refcnt;
        w_wuses    = COUNT_BITS'(1);
        w_wref     = 1'b0;
        if (i_cmd.load) begin
            w_waddr    = w_victim;
            w_we_page  = 1'b1;
            w_we_stamp = 1'b1;
            w_we_uses  = 1'b1;
            w_we_ref   = 1'b1;
        end else if (i_cmd.clr_ref) begin
            w_we_ref = 1'b1;
        end else if (i_cmd.hit_upd) begin
            case (w_mode)
                POL_LRU: w_we_stamp = 1'b1;
                POL_LFU, POL_MFU: begin
                    w_we_uses = 1'b1;
                    w_wuses   = (r_rd_uses != '1) ? r_rd_uses + 1'b1 : r_rd_uses;
                end
                POL_CLOCK: begin
                    w_we_ref = 1'b1;
                    w_wref   = 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we_page)  mem_page[w_waddr]  <= r_page;
        if (w_we_stamp) mem_stamp[w_waddr] <= w_wstamp;
        if (w_we_uses)  mem_uses[w_waddr]  <= w_wuses;
        if (w_we_ref)   mem_ref[w_waddr]   <= w_wref;
        if (i_cmd.issue) begin
            r_rd_page  <= mem_page[r_addr];
            r_rd_stamp <= mem_stamp[r_addr];
            r_rd_uses  <= mem_uses[r_addr];
            r_rd_ref   <= mem_ref[r_addr];
        end
    end

    // Control state and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_mode   <= MODE_W'(POL_FIFO);
            r_cfg_frames <= NFRAMES_RESET;
            r_filled     <= '0;
            r_hand       <= '0;
            r_refcnt     <= '0;
            r_hits       <= '0;
            r_faults     <= '0;
            r_dv         <= 1'b0;
        end else begin
            r_dv <= i_cmd.issue;
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_POLICY_MODE:   r_cfg_mode   <= i_cfg_data[MODE_W-1:0];
                    CFG_FRAMES_IN_USE: r_cfg_frames <= i_cfg_data[NFRAMES_W-1:0];
                    default: ;
                endcase
                r_filled <= '0;
                r_hand   <= '0;
                r_refcnt <= '0;
                r_hits   <= '0;
                r_faults <= '0;
            end else begin
                if (i_cmd.load) begin
                    if (i_cmd.load_sel == LD_EMPTY) begin
                        r_filled <= w_filled_inc;
                        r_hand   <= (w_filled_inc == w_count) ? '0 : w_filled_inc[FIDX-1:0];
                    end else if (w_mode == POL_CLOCK) begin
                        r_hand <= f_next(w_victim, w_count);
                    end
                end
                if (i_cmd.emit) begin
                    if (r_refcnt != '1) r_refcnt <= r_refcnt + 1'b1;
                    if (r_res_hit) begin
                        if (r_hits != '1) r_hits <= r_hits + 1'b1;
                    end else begin
                        if (r_faults != '1) r_faults <= r_faults + 1'b1;
                    end
                end
            end
        end
    end

    // Scan, tracking and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_page   <= PAGE_BITS'(i_page);
            r_addr   <= '0;
            r_issued <= '0;
            r_sweep  <= 1'b0;
            r_best_v <= 1'b0;
        end else if (i_cmd.sweep_start) begin
            r_addr   <= r_hand;
            r_issued <= '0;
            r_sweep  <= 1'b1;
            r_best_v <= 1'b0;
        end else begin
            if (i_cmd.issue) begin
                r_addr   <= f_next(r_addr, w_count);
                r_issued <= r_issued + 1'b1;
            end
            if (i_cmd.track && w_take) begin
                r_best_v     <= 1'b1;
                r_best_idx   <= r_didx;
                r_best_page  <= r_rd_page;
                r_best_stamp <= r_rd_stamp;
                r_best_uses  <= r_rd_uses;
            end
        end
        if (i_cmd.issue) r_didx <= r_addr;

        if (i_cmd.hit_upd) begin
            r_res_hit   <= 1'b1;
            r_res_slot  <= r_didx;
            r_res_evict <= 1'b0;
            r_res_old   <= '0;
        end else if (i_cmd.load) begin
            r_res_hit   <= 1'b0;
            r_res_slot  <= w_victim;
            r_res_evict <= (i_cmd.load_sel != LD_EMPTY);
            r_res_old   <= w_victim_page;
        end

        if (i_cmd.emit) begin
            r_out_hit   <= r_res_hit;
            r_out_frame <= FRAME_W'(r_res_slot);
            r_out_evict <= r_res_evict;
            r_out_old   <= PAGE_W'(r_res_old);
        end
    end

    assign o_sts.dv         = r_dv;
    assign o_sts.match      = r_dv && (r_rd_page == r_page);
    assign o_sts.refbit     = r_rd_ref;
    assign o_sts.all_issued = (r_issued == (r_sweep ? w_count : r_filled));
    assign o_sts.full       = (r_filled == w_count);
    assign o_sts.clock      = (w_mode == POL_CLOCK);

    assign o_hit           = r_out_hit;
    assign o_frame_used    = r_out_frame;
    assign o_evicted_valid = r_out_evict;
    assign o_evicted_page  = r_out_old;
    assign o_hit_total     = r_hits;
    assign o_fault_total   = r_faults;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_filled <= w_count)
        else $error("fill count beyond active frames");

    a_hand_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CNTW'(r_hand) < w_count)
        else $error("clock hand beyond active frames");

    a_read_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dv |-> CNTW'(r_didx) < w_count)
        else $error("table read beyond active frames");
`endif

endmodule

@@ src/page_replacement_engine.sv @@
// Page replacement engine: FIFO, LRU, LFU, MFU or clock over a table of resident frames.
// Each page reference is looked up by scanning the filled frames one per cycle through the
// frame table's single read port; a miss on a full table picks its victim during the same
// scan, except in clock mode, which then sweeps again from the hand, clearing reference bits
// as it passes. A finished item waits until the output register is free.
// The next reference is accepted while the previous result still waits at the output.
// Writing either configuration register empties the table and clears the totals.
module page_replacement_engine import pre_pkg::*; #(
    parameter int FRAMES     = DEF_FRAMES,
    parameter int PAGE_BITS  = DEF_PAGE_BITS,
    parameter int STAMP_BITS = DEF_STAMP_BITS,
    parameter int COUNT_BITS = DEF_COUNT_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [PAGE_W-1:0]     i_page,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_hit,
    output logic [FRAME_W-1:0]    o_frame_used,
    output logic                  o_evicted_valid,
    output logic [PAGE_W-1:0]     o_evicted_page,
    output logic [TOTAL_W-1:0]    o_hit_total,
    output logic [TOTAL_W-1:0]    o_fault_total
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    pre_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    pre_datapath #(
        .FRAMES     (FRAMES),
        .PAGE_BITS  (PAGE_BITS),
        .STAMP_BITS (STAMP_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_page          (i_page),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .o_hit           (o_hit),
        .o_frame_used    (o_frame_used),
        .o_evicted_valid (o_evicted_valid),
        .o_evicted_page  (o_evicted_page),
        .o_hit_total     (o_hit_total),
        .o_fault_total   (o_fault_total)
    );

endmodule

@@ tb/tb_page_replacement_engine.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for page_replacement_engine: predicts every result and checks all policies.
module tb_page_replacement_engine;
    import pre_pkg::*;

    localparam int NUM_FRAMES    = 16;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = 60;
    localparam int POOL_DEPTH    = 32;
    localparam logic [MODE_W-1:0] POL_UNUSED_TOP = 3'd7;

    typedef struct packed {
        logic               hit;
        logic [FRAME_W-1:0] frame;
        logic               ev_valid;
        logic [PAGE_W-1:0]  ev_page;
        logic [TOTAL_W-1:0] hit_total;
        logic [TOTAL_W-1:0] fault_total;
    } t_outcome;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = CFG_POLICY_MODE;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic [PAGE_W-1:0]     i_page = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic                  o_hit;
    logic [FRAME_W-1:0]    o_frame_used;
    logic                  o_evicted_valid;
    logic [PAGE_W-1:0]     o_evicted_page;
    logic [TOTAL_W-1:0]    o_hit_total;
    logic [TOTAL_W-1:0]    o_fault_total;

    page_replacement_engine dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_page         (i_page),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_hit          (o_hit),
        .o_frame_used   (o_frame_used),
        .o_evicted_valid(o_evicted_valid),
        .o_evicted_page (o_evicted_page),
        .o_hit_total    (o_hit_total),
        .o_fault_total  (o_fault_total)
    );

    // Predicted frame table
    logic [MODE_W-1:0]    mdl_policy;
    logic [NFRAMES_W-1:0] mdl_frames;
    logic [PAGE_W-1:0]    res_page   [NUM_FRAMES];
    logic [31:0]          res_stamp  [NUM_FRAMES];
    logic [15:0]          res_uses   [NUM_FRAMES];
    logic                 res_refbit [NUM_FRAMES];
    int                   filled;
    int                   hand;
    logic [31:0]          ref_stamp;
    logic [TOTAL_W-1:0]   hits;
    logic [TOTAL_W-1:0]   faults;

    t_outcome          pending_results[$];
    t_outcome          want;
    int                mismatches = 0;
    int                cycles = 0;
    logic [PAGE_W-1:0] page_pool [POOL_DEPTH];

    // Sender and receiver pacing
    bit tx_idle_en = 1'b1;
    int burst_left = 0;
    int rx_mode = 0;
    int rx_tick = 0;
    int stall_left = 0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_page_replacement_engine failed");
            $finish;
        end
    end

    function automatic void clear_residency();
        for (int i = 0; i < NUM_FRAMES; i++) begin
            res_page[i]   = '0;
            res_stamp[i]  = '0;
            res_uses[i]   = '0;
            res_refbit[i] = 1'b0;
        end
        filled    = 0;
        hand      = 0;
        ref_stamp = '0;
        hits      = '0;
        faults    = '0;
    endfunction

    // True if frame a should be replaced ahead of frame b
    function automatic bit better_victim(t_policy pol, int a, int b);
        if (pol == POL_LFU && res_uses[a] != res_uses[b])
            return res_uses[a] < res_uses[b];
        if (pol == POL_MFU && res_uses[a] != res_uses[b])
            return res_uses[a] > res_uses[b];
        return res_stamp[a] < res_stamp[b];
    endfunction

    function automatic t_outcome predict_reference(logic [PAGE_W-1:0] pg);
        t_outcome r;
        t_policy  pol;
        int       count;
        int       slot;
        int       h;
        bit       found;
        bit       swept;
        r     = '0;
        pol   = (mdl_policy > POL_CLOCK) ? POL_FIFO : t_policy'(mdl_policy);
        count = (mdl_frames == 0) ? 1 :
                (mdl_frames > NUM_FRAMES) ? NUM_FRAMES : int'(mdl_frames);
        if (filled > count) filled = count;
        found = 1'b0;
        slot  = 0;
        for (int i = 0; i < filled; i++) begin
            if (!found && res_page[i] == pg) begin
                found = 1'b1;
                slot  = i;
            end
        end
        if (found) begin
            case (pol)
                POL_LRU:          res_stamp[slot] = ref_stamp;
                POL_LFU, POL_MFU: if (res_uses[slot] != 16'hFFFF) res_uses[slot]++;
                POL_CLOCK:        res_refbit[slot] = 1'b1;
                default:          ;
            endcase
            if (hits != '1) hits++;
        end else begin
            if (filled < count) begin
                slot = filled;
                filled++;
                hand = filled % count;
            end else begin
                if (pol == POL_CLOCK) begin
                    // clear and pass set bits; with every bit set, land back on the hand
                    h     = hand % count;
                    swept = 1'b0;
                    for (int i = 0; i < count; i++) begin
                        if (!swept) begin
                            if (!res_refbit[h]) begin
                                swept = 1'b1;
                            end else begin
                                res_refbit[h] = 1'b0;
                                h = (h + 1) % count;
                            end
                        end
                    end
                    hand = (h + 1) % count;
                    slot = h;
                end else begin
                    slot = 0;
                    for (int i = 1; i < count; i++)
                        if (better_victim(pol, i, slot)) slot = i;
                end
                r.ev_valid = 1'b1;
                r.ev_page  = res_page[slot];
            end
            res_page[slot]   = pg;
            res_stamp[slot]  = ref_stamp;
            res_uses[slot]   = 16'd1;
            res_refbit[slot] = 1'b0;
            if (faults != '1) faults++;
        end
        if (ref_stamp != '1) ref_stamp++;
        r.hit         = found;
        r.frame       = FRAME_W'(slot);
        r.hit_total   = hits;
        r.fault_total = faults;
        return r;
    endfunction

    // Receiver: stall on a pattern chosen per test
    always @(negedge i_clk) begin
        rx_tick++;
        case (rx_mode)
            0: i_out_ready = 1'b1;
            1: i_out_ready = 1'($urandom_range(0, 1));
            2: i_out_ready = (rx_tick % 7) < 4;
            default: begin
                if (stall_left > 0) begin
                    stall_left--;
                    i_out_ready = 1'b0;
                end else if ($urandom_range(0, 15) == 0) begin
                    stall_left  = $urandom_range(5, 30);
                    i_out_ready = 1'b0;
                end else begin
                    i_out_ready = 1'b1;
                end
            end
        endcase
    end

    task automatic report_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
        if (exp_val !== act_val) begin
            mismatches++;
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_val, act_val);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                $display("%0t: result transaction with no reference pending", $time);
            end else begin
                want = pending_results.pop_front();
                report_field("hit", 32'(want.hit), 32'(o_hit));
                report_field("frame_used", 32'(want.frame), 32'(o_frame_used));
                report_field("evicted_valid", 32'(want.ev_valid), 32'(o_evicted_valid));
                report_field("evicted_page", 32'(want.ev_page), 32'(o_evicted_page));
                report_field("hit_total", want.hit_total, o_hit_total);
                report_field("fault_total", want.fault_total, o_fault_total);
            end
        end
    end

    task automatic send_page(logic [PAGE_W-1:0] pg);
        int gap;
        @(negedge i_clk);
        i_in_valid = 1'b1;
        i_page     = pg;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        pending_results.push_back(predict_reference(pg));
        if (tx_idle_en) begin
            if (burst_left == 0) begin
                gap        = $urandom_range(1, 8);
                burst_left = $urandom_range(1, 12);
                @(negedge i_clk);
                i_in_valid = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx == CFG_POLICY_MODE) mdl_policy = val[MODE_W-1:0];
        else mdl_frames = val;
        clear_residency();
    endtask

    task automatic configure(logic [MODE_W-1:0] pol, logic [NFRAMES_W-1:0] fr);
        wait_idle();
        write_reg(CFG_POLICY_MODE, CFG_DATA_W'(pol));
        write_reg(CFG_FRAMES_IN_USE, fr);
    endtask

    // Mostly references from a small pool so hits and evictions both happen
    task automatic run_references(int n, int pool_size);
        for (int i = 0; i < POOL_DEPTH; i++) page_pool[i] = PAGE_W'($urandom);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) == 0) send_page(PAGE_W'($urandom));
            else send_page(page_pool[$urandom_range(0, pool_size - 1)]);
        end
    endtask

    task automatic test_directed();
        rx_mode    = 1;
        tx_idle_en = 1'b1;
        // reset defaults: FIFO over sixteen frames
        send_page(16'h0000);
        send_page(16'hFFFF);
        send_page(16'h0000);
        // LRU: the refreshed page survives
        configure(POL_LRU, 5'd2);
        send_page(16'h0001);
        send_page(16'h0002);
        send_page(16'h0001);
        send_page(16'h0003);
        // LFU drops the less used page, MFU the more used one
        configure(POL_LFU, 5'd2);
        send_page(16'h0005);
        send_page(16'h0006);
        send_page(16'h0005);
        send_page(16'h0007);
        configure(POL_MFU, 5'd2);
        send_page(16'h0005);
        send_page(16'h0006);
        send_page(16'h0005);
        send_page(16'h0007);
        // clock with every reference bit set replaces at the hand
        configure(POL_CLOCK, 5'd2);
        send_page(16'h0008);
        send_page(16'h0009);
        send_page(16'h0008);
        send_page(16'h0009);
        send_page(16'h000A);
        // unused policy code and a zero frame count
        configure(POL_UNUSED_TOP, 5'd0);
        send_page(16'hAAAA);
        send_page(16'h5555);
        send_page(16'h5555);
        // frame count above the table size
        configure(POL_FIFO, 5'd31);
        send_page(16'h1234);
    endtask

    task automatic test_policy_sweep();
        t_policy pol;
        int      fr;
        for (int p = POL_FIFO; p <= POL_CLOCK; p++) begin
            pol = t_policy'(p);
            for (int k = 0; k < 2; k++) begin
                fr      = (k == 0) ? 4 : NUM_FRAMES;
                rx_mode = (p + k) % 4;
                configure(pol, NFRAMES_W'(fr));
                run_references(60, fr + fr / 2 + 1);
            end
        end
    endtask

    task automatic test_random_configs();
        int fr;
        int pol;
        int eff;
        for (int ph = 0; ph < 6; ph++) begin
            rx_mode = $urandom_range(0, 3);
            if (ph == 0) begin
                pol = POL_CLOCK;
                fr  = 1;
            end else if (ph == 5) begin
                pol = POL_LFU;
                fr  = 31;
            end else begin
                pol = $urandom_range(0, 7);
                fr  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 8);
            end
            configure(MODE_W'(pol), NFRAMES_W'(fr));
            eff = (fr == 0) ? 1 : (fr > NUM_FRAMES) ? NUM_FRAMES : fr;
            run_references(60, eff + eff / 2 + 1);
        end
    endtask

    task automatic test_back_to_back();
        tx_idle_en = 1'b0;
        rx_mode    = 0;
        configure(POL_CLOCK, 5'd16);
        run_references(150, 20);
        tx_idle_en = 1'b1;
    endtask

    initial begin
        mdl_policy = POL_FIFO;
        mdl_frames = NFRAMES_RESET;
        clear_residency();
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_policy_sweep();
        test_random_configs();
        test_back_to_back();
        wait_idle();
        if (mismatches == 0) begin
            $display("tb_page_replacement_engine passed");
        end else begin
            $display("tb_page_replacement_engine failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
src/pre_pkg.sv
src/pre_ctrl.sv
src/pre_datapath.sv
src/page_replacement_engine.sv
tb/tb_page_replacement_engine.sv
